/* hw/rtl/bdlp_pkg.sv */
// bdlp_pkg: shared types and constants of the button debounce and long press core
// configuration register indexes, reset values, the configuration struct and the lane status struct
// no dependencies
package bdlp_pkg;

    localparam int NUM_BUTTONS_DEF = 8;
    localparam int MAX_BUTTONS     = 8;
    localparam int PIN_W           = 8;
    localparam int PIN_SEL_W       = 3;
    localparam int SCORE_W         = 8;
    localparam int HOLD_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_RELEASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MAX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_MAP        = 3'd5;

    localparam logic                  RST_ACTIVE_LEVEL   = 1'b0;
    localparam logic [SCORE_W-1:0]    RST_SCORE_MAX      = 8'd10;
    localparam logic [SCORE_W-1:0]    RST_SCORE_RELEASE  = 8'd5;
    localparam logic [HOLD_W-1:0]     RST_HOLD_MAX       = 16'd1000;
    localparam logic [HOLD_W-1:0]     RST_HOLD_THRESHOLD = 16'd500;
    localparam logic [CFG_DATA_W-1:0] RST_PIN_MAP        = 24'hFAC688;

    typedef struct packed {
        logic                  active_level;
        logic [SCORE_W-1:0]    score_max;
        logic [SCORE_W-1:0]    score_release;
        logic [HOLD_W-1:0]     hold_max;
        logic [HOLD_W-1:0]     hold_threshold;
        logic [CFG_DATA_W-1:0] pin_map;
    } t_cfg;

    typedef struct packed {
        logic pressed;
        logic long_press;
        logic changed;
    } t_lane_status;

endpackage

/* hw/rtl/bdlp_cfg.sv */
// bdlp_cfg: configuration register file of the debounce core
// plain write port, no read-back; uses bdlp_pkg
module bdlp_cfg
    import bdlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level   <= RST_ACTIVE_LEVEL;
            r_cfg.score_max      <= RST_SCORE_MAX;
            r_cfg.score_release  <= RST_SCORE_RELEASE;
            r_cfg.hold_max       <= RST_HOLD_MAX;
            r_cfg.hold_threshold <= RST_HOLD_THRESHOLD;
            r_cfg.pin_map        <= RST_PIN_MAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_LEVEL:   r_cfg.active_level   <= i_cfg_data[0];
                CFG_SCORE_MAX:      r_cfg.score_max      <= i_cfg_data[SCORE_W-1:0];
                CFG_SCORE_RELEASE:  r_cfg.score_release  <= i_cfg_data[SCORE_W-1:0];
                CFG_HOLD_MAX:       r_cfg.hold_max       <= i_cfg_data[HOLD_W-1:0];
                CFG_HOLD_THRESHOLD: r_cfg.hold_threshold <= i_cfg_data[HOLD_W-1:0];
                CFG_PIN_MAP:        r_cfg.pin_map        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/bdlp_lane.sv */
// bdlp_lane: state and next-state logic of one button
// integrator, pressed flag, hold counter and long press flag; uses bdlp_pkg
module bdlp_lane
    import bdlp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_level,
    input  t_cfg         i_cfg,
    output t_lane_status o_status
);

    logic [SCORE_W-1:0] r_score, n_score, score_step;
    logic [HOLD_W-1:0]  r_hold, n_hold;
    logic               r_pressed, n_pressed;
    logic               r_long, n_long;
    logic               n_flip;
    logic               active;

    always_comb begin
        active     = (i_level == i_cfg.active_level);
        score_step = r_score;
        if (active && r_score < i_cfg.score_max) begin
            score_step = r_score + 8'd1;
        end
        if (!active && r_score != '0) begin
            score_step = r_score - 8'd1;
        end
        n_score   = score_step;
        n_hold    = r_hold;
        n_pressed = r_pressed;
        n_long    = r_long;
        n_flip    = 1'b0;
        if (r_pressed) begin
            if (score_step < i_cfg.score_release) begin
                n_pressed = 1'b0;
                n_hold    = '0;
                n_long    = 1'b0;
                n_flip    = 1'b1;
            end else if (score_step == i_cfg.score_max) begin
                if (r_hold < i_cfg.hold_max) begin
                    n_hold = r_hold + 16'd1;
                end
                if (n_hold > i_cfg.hold_threshold) begin
                    n_long = 1'b1;
                end
            end
        end else if (score_step == i_cfg.score_max) begin
            n_pressed = 1'b1;
            n_flip    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score   <= '0;
            r_hold    <= '0;
            r_pressed <= 1'b0;
            r_long    <= 1'b0;
        end else if (i_en) begin
            r_score   <= n_score;
            r_hold    <= n_hold;
            r_pressed <= n_pressed;
            r_long    <= n_long;
        end
    end

    assign o_status.pressed    = n_pressed;
    assign o_status.long_press = n_long;
    assign o_status.changed    = n_flip;

endmodule

/* hw/rtl/button_debounce_long_press_core.sv */
// button_debounce_long_press_core: debounce and long press detection for up to eight buttons
// one sample of eight pins in, one item of three button masks out
// depends on bdlp_pkg, bdlp_cfg, bdlp_lane
//
// usage
//   slave stream: i_s_tdata carries one 8-bit pin sample per item
//   master stream: o_m_tdata carries pressed, long press and changed masks
//   configuration: i_cfg_we, i_cfg_index, i_cfg_data write one register per
//   cycle; the user must write only while no item is in flight, the block itself has no guard
// timing
//   an accepted sample lands in an input register; once the output register is
//   empty or draining, all buttons update together and the masks load into
//   the output register, which drives o_m_tvalid
//   throughput is one item per cycle while i_m_tready stays high, set by the
//   single per-button update step
// reset
//   i_rst_n low clears all button state and restores register defaults
// stall
//   while i_m_tready is low the output holds, one more sample can wait in the
//   input register, then o_s_tready drops until the output drains
module button_debounce_long_press_core
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // sample_pins
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [23:0]           o_m_tdata    // pressed_mask, long_press_mask, changed_mask
);

    t_cfg cfg;

    logic             r_s1_valid;
    logic [PIN_W-1:0] r_in_pins;
    logic             s1_advance;
    logic             lane_en;

    logic             r_out_valid;
    logic [7:0]       r_pressed_mask, r_long_mask, r_changed_mask;
    logic [7:0]       n_pressed_mask, n_long_mask, n_changed_mask;

    bdlp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign s1_advance = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_advance;
    assign lane_en    = r_s1_valid && s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_pins <= i_s_tdata;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BUTTONS; gi++) begin : g_lane
            if (gi < NUM_BUTTONS) begin : g_used
                t_lane_status           status;
                logic [PIN_SEL_W-1:0]   pin_sel;

                assign pin_sel = cfg.pin_map[PIN_SEL_W*gi +: PIN_SEL_W];

                bdlp_lane u_lane (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_en     (lane_en),
                    .i_level  (r_in_pins[pin_sel]),
                    .i_cfg    (cfg),
                    .o_status (status)
                );

                assign n_pressed_mask[gi] = status.pressed;
                assign n_long_mask[gi]    = status.long_press;
                assign n_changed_mask[gi] = status.changed;
            end else begin : g_unused
                assign n_pressed_mask[gi] = 1'b0;
                assign n_long_mask[gi]    = 1'b0;
                assign n_changed_mask[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_en) begin
            r_pressed_mask <= n_pressed_mask;
            r_long_mask    <= n_long_mask;
            r_changed_mask <= n_changed_mask;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_changed_mask, r_long_mask, r_pressed_mask};

    // long press only on a pressed button
    a_long_within_pressed: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_long_mask & ~r_pressed_mask) == 8'd0)
    ) else $error("long press set on a released button");

    // a held input item keeps its sample
    a_s1_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |=> (r_s1_valid && $stable(r_in_pins))
    ) else $error("waiting input item lost");

    // an empty output register never stalls the input side
    a_ready_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready
    ) else $error("input stalled with empty output register");

    // buttons beyond the configured count stay quiet
    a_unused_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (((r_pressed_mask | r_changed_mask) >> NUM_BUTTONS) == 8'd0)
    ) else $error("unused button bit set");

endmodule

/* test/tb_button_debounce_long_press_core.sv */
// tb_button_debounce_long_press_core: self-checking testbench of the button debounce core
// drives pin samples with random gaps and stalls, predicts the three masks per item
// depends on bdlp_pkg and button_debounce_long_press_core
`timescale 1ns / 1ps

module tb_button_debounce_long_press_core;
    import bdlp_pkg::*;

    localparam int NUM_BTN = NUM_BUTTONS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int DRAIN_LIMIT   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] changed;
        logic [7:0] long_press;
        logic [7:0] pressed;
    } t_button_masks;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata   = '0;  // sample_pins
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [23:0]           o_m_tdata;         // pressed_mask, long_press_mask, changed_mask

    // button state and register copy of the predictor
    t_cfg        cfg_mirror;
    logic [7:0]  btn_score   [NUM_BTN] = '{default: '0};
    logic        btn_pressed [NUM_BTN] = '{default: 1'b0};
    logic [15:0] btn_hold    [NUM_BTN] = '{default: '0};
    logic        btn_long    [NUM_BTN] = '{default: 1'b0};

    t_button_masks masks_due[$];
    int            fail_count   = 0;
    int            results_seen = 0;
    int            rx_wait      = 0;
    bit            tx_steady    = 1'b0;
    bit            rx_steady    = 1'b0;

    always #4 i_clk = ~i_clk;

    button_debounce_long_press_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    function automatic t_cfg make_cfg(input logic al, input logic [7:0] smax,
                                      input logic [7:0] srel, input logic [15:0] hmax,
                                      input logic [15:0] hthr, input logic [23:0] map);
        t_cfg c;
        c.active_level   = al;
        c.score_max      = smax;
        c.score_release  = srel;
        c.hold_max       = hmax;
        c.hold_threshold = hthr;
        c.pin_map        = map;
        return c;
    endfunction

    // advances every button by one sample and returns the masks of that item
    function automatic t_button_masks debounce_step(input logic [7:0] pins);
        t_button_masks r;
        logic [2:0]    sel;
        logic          act;
        r = '0;
        for (int b = 0; b < NUM_BTN; b++) begin
            sel = cfg_mirror.pin_map[3*b +: 3];
            act = (pins[sel] == cfg_mirror.active_level);
            if (act && btn_score[b] < cfg_mirror.score_max)
                btn_score[b] = btn_score[b] + 8'd1;
            if (!act && btn_score[b] > 8'd0)
                btn_score[b] = btn_score[b] - 8'd1;
            if (btn_pressed[b]) begin
                if (btn_score[b] < cfg_mirror.score_release) begin
                    btn_pressed[b] = 1'b0;
                    btn_hold[b]    = '0;
                    btn_long[b]    = 1'b0;
                    r.changed[b]   = 1'b1;
                end else if (btn_score[b] == cfg_mirror.score_max) begin
                    if (btn_hold[b] < cfg_mirror.hold_max)
                        btn_hold[b] = btn_hold[b] + 16'd1;
                    if (btn_hold[b] > cfg_mirror.hold_threshold)
                        btn_long[b] = 1'b1;
                end
            end else if (btn_score[b] == cfg_mirror.score_max) begin
                btn_pressed[b] = 1'b1;
                r.changed[b]   = 1'b1;
            end
            r.pressed[b]    = btn_pressed[b];
            r.long_press[b] = btn_long[b];
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("error: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
            note_failure($sformatf("item %0d %s expected %h got %h",
                                   results_seen, name, exp_v, act_v));
    endtask

    // result side: random stalls after each item, with calm stretches
    always @(posedge i_clk) begin : rx_side
        int n;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n = rx_steady ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                i_m_tready <= 1'b0;
                rx_wait    <= n - 1;
            end
        end else if (!i_m_tready) begin
            if (rx_wait == 0)
                i_m_tready <= 1'b1;
            else
                rx_wait <= rx_wait - 1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_button_masks due;
        t_button_masks got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (masks_due.size() == 0) begin
                note_failure($sformatf("unexpected item %h", o_m_tdata));
            end else begin
                due = masks_due.pop_front();
                check_field("pressed", due.pressed, got.pressed);
                check_field("long press", due.long_press, got.long_press);
                check_field("changed", due.changed, got.changed);
            end
            results_seen++;
        end
    end

    task automatic send_sample(input logic [7:0] pins);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pins;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        masks_due.push_back(debounce_step(pins));
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        i_s_tvalid <= 1'b0;
        while (masks_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (masks_due.size() != 0) begin
            note_failure($sformatf("%0d items never came out", masks_due.size()));
            masks_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ACTIVE_LEVEL:   cfg_mirror.active_level   = data[0];
            CFG_SCORE_MAX:      cfg_mirror.score_max      = data[SCORE_W-1:0];
            CFG_SCORE_RELEASE:  cfg_mirror.score_release  = data[SCORE_W-1:0];
            CFG_HOLD_MAX:       cfg_mirror.hold_max       = data[HOLD_W-1:0];
            CFG_HOLD_THRESHOLD: cfg_mirror.hold_threshold = data[HOLD_W-1:0];
            CFG_PIN_MAP:        cfg_mirror.pin_map        = data;
            default: ;
        endcase
    endtask

    task automatic program_cfg(input t_cfg c);
        wait_idle();
        write_reg(CFG_ACTIVE_LEVEL, {23'd0, c.active_level});
        write_reg(CFG_SCORE_MAX, {16'd0, c.score_max});
        write_reg(CFG_SCORE_RELEASE, {16'd0, c.score_release});
        write_reg(CFG_HOLD_MAX, {8'd0, c.hold_max});
        write_reg(CFG_HOLD_THRESHOLD, {8'd0, c.hold_threshold});
        write_reg(CFG_PIN_MAP, c.pin_map);
        i_cfg_we <= 1'b0;
    endtask

    // runs of a held pin pattern with occasional single-pin bounce
    task automatic run_samples(input int count, input int min_run, input int max_run,
                               input int bounce_pct, input bit alternate);
        logic [7:0] level_pat;
        logic [7:0] pins;
        int         run_left;
        level_pat = 8'($urandom_range(0, 255));
        run_left  = 0;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                if (alternate)
                    level_pat = ~level_pat;
                else if ($urandom_range(0, 3) == 0)
                    level_pat = 8'($urandom_range(0, 255));
                else
                    level_pat = level_pat ^ 8'($urandom_range(1, 255));
                run_left = $urandom_range(min_run, max_run);
            end
            if ($urandom_range(0, 49) == 0) begin
                tx_steady <= ($urandom_range(0, 2) == 0);
                rx_steady <= ($urandom_range(0, 2) == 0);
            end
            pins = level_pat;
            if ($urandom_range(0, 99) < bounce_pct)
                pins = pins ^ (8'd1 << $urandom_range(0, 7));
            send_sample(pins);
            run_left--;
        end
    endtask

    task automatic test_reset_defaults();
        repeat (11) send_sample(8'h00);
        repeat (6) send_sample(8'hFF);
        send_sample(8'h55);
        send_sample(8'hAA);
        send_sample(8'h80);
        send_sample(8'h01);
    endtask

    task automatic test_spare_index();
        wait_idle();
        write_reg(CFG_SPARE_LO, 24'hFFFFFF);
        write_reg(CFG_SPARE_HI, 24'hFFFFFF);
        i_cfg_we <= 1'b0;
        send_sample(8'h00);
        send_sample(8'hFF);
    endtask

    // zero maxima, and scores left above the new maximum
    task automatic test_zero_limits();
        program_cfg(make_cfg(1'b0, 8'd0, 8'd0, 16'd0, 16'd0, RST_PIN_MAP));
        send_sample(8'h00);
        repeat (5) send_sample(8'hFF);
        send_sample(8'h00);
    endtask

    task automatic test_random_phases();
        program_cfg(make_cfg(1'b0, 8'd4, 8'd2, 16'd12, 16'd6, RST_PIN_MAP));
        run_samples(200, 1, 40, 5, 1'b0);
        program_cfg(make_cfg(1'b1, 8'd3, 8'd3, 16'd5, 16'd0,
                             24'($urandom_range(0, 24'hFFFFFF))));
        run_samples(200, 1, 30, 10, 1'b0);
        program_cfg(make_cfg(1'b0, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
        run_samples(540, 256, 270, 0, 1'b1);
        program_cfg(make_cfg(1'b1, 8'd1, 8'd0, 16'hFFFF, 16'd20,
                             24'($urandom_range(0, 24'hFFFFFF))));
        run_samples(150, 1, 8, 20, 1'b0);
        program_cfg(make_cfg(1'b0, 8'd0, 8'd0, 16'd0, 16'd0,
                             24'($urandom_range(0, 24'hFFFFFF))));
        run_samples(100, 1, 6, 20, 1'b0);
        program_cfg(make_cfg(1'b1, 8'd8, 8'd6, 16'd3, 16'd3,
                             24'($urandom_range(0, 24'hFFFFFF))));
        run_samples(170, 1, 24, 10, 1'b0);
        program_cfg(make_cfg(1'b0, 8'd6, 8'd1, 16'd1, 16'd0, 24'h000000));
        run_samples(170, 1, 20, 5, 1'b0);
        program_cfg(make_cfg(1'($urandom_range(0, 1)), 8'($urandom_range(1, 12)),
                             8'($urandom_range(0, 13)), 16'($urandom_range(1, 20)),
                             16'($urandom_range(0, 22)),
                             24'($urandom_range(0, 24'hFFFFFF))));
        run_samples(150, 1, 3, 30, 1'b0);
        program_cfg(make_cfg(RST_ACTIVE_LEVEL, RST_SCORE_MAX, RST_SCORE_RELEASE,
                             RST_HOLD_MAX, RST_HOLD_THRESHOLD, RST_PIN_MAP));
        run_samples(100, 1, 30, 5, 1'b0);
    endtask

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        cfg_mirror = make_cfg(RST_ACTIVE_LEVEL, RST_SCORE_MAX, RST_SCORE_RELEASE,
                              RST_HOLD_MAX, RST_HOLD_THRESHOLD, RST_PIN_MAP);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_spare_index();
        test_zero_limits();
        test_random_phases();
        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
